// File: sv/xcfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfd_pkg: shared types and constants of the XOR-checked frame decoder
// Phase codes, field widths and the start-of-frame marker.
// ----------------------------------------------------------------------------
package xcfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;

  localparam logic [ByteW-1:0] StartByte = 8'hFE;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    PH_WAIT     = 3'd0,
    PH_FUNC_MSB = 3'd1,
    PH_FUNC_LSB = 3'd2,
    PH_LEN_MSB  = 3'd3,
    PH_LEN_LSB  = 3'd4,
    PH_PAYLOAD  = 3'd5,
    PH_CHECKSUM = 3'd6
  } phase_e;

  typedef enum logic {
    KIND_PAYLOAD   = 1'b0,
    KIND_FRAME_END = 1'b1
  } kind_e;

  typedef struct packed {
    logic  result_kind;
    word_t function_code;
    word_t payload_length;
    word_t byte_index;
    byte_t byte_value;
    logic  checksum_ok;
  } result_t;

endpackage
`default_nettype wire

// File: sv/xcfd_rx_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfd_rx_if: received byte channel
// Valid/ready channel carrying one received byte per transaction.
// ----------------------------------------------------------------------------
interface xcfd_rx_if;
  logic             valid;
  logic             ready;
  xcfd_pkg::byte_t  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: sv/xcfd_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfd_res_if: decoded result channel
// Valid/ready channel carrying a payload byte or a frame-end report.
// ----------------------------------------------------------------------------
interface xcfd_res_if;
  logic             valid;
  logic             ready;
  logic             result_kind;
  xcfd_pkg::word_t  function_code;
  xcfd_pkg::word_t  payload_length;
  xcfd_pkg::word_t  byte_index;
  xcfd_pkg::byte_t  byte_value;
  logic             checksum_ok;

  modport source (output valid, output result_kind, output function_code,
                  output payload_length, output byte_index, output byte_value,
                  output checksum_ok, input ready);
  modport sink   (input valid, input result_kind, input function_code,
                  input payload_length, input byte_index, input byte_value,
                  input checksum_ok, output ready);
endinterface
`default_nettype wire

// File: sv/xor_checked_frame_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xor_checked_frame_decoder_unit: start/length framed decoder with XOR check
// Hunts for 0xFE, reads function code and length, streams payload bytes with
// their index and reports frame end with a checksum-ok flag.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  rx_i    | in  | one received byte (rx_byte)
//  res_o   | out | payload byte with index, or frame-end report
//
//  One byte per cycle sustained while res_o is ready. A byte is held in the input
//  register, then the parser updates its state and loads the result register.
//  Async active-low reset returns the parser to hunting for the start byte.
//  A stalled result register stalls the input register and then rx_i.ready.
// ----------------------------------------------------------------------------
module xor_checked_frame_decoder_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  xcfd_rx_if.sink     rx_i,
  xcfd_res_if.source  res_o
);
  import xcfd_pkg::*;

  // input register
  logic    in_vld_q;
  byte_t   in_byte_q;

  // parser state
  phase_e  phase_q, phase_d;
  word_t   func_q, func_d;
  word_t   len_q, len_d;
  word_t   cnt_q, cnt_d;
  byte_t   xor_q, xor_d;

  // result register
  logic    out_vld_q, out_vld_d;
  result_t res_q, res_d;
  logic    emit;

  logic    advance;
  word_t   cnt_inc;

  assign advance    = !out_vld_q || res_o.ready;
  assign rx_i.ready = !in_vld_q || advance;
  assign cnt_inc    = cnt_q + word_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    func_d  = func_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    xor_d   = xor_q;
    if (in_vld_q && advance) begin
      case (phase_q)
        PH_WAIT: begin
          if (in_byte_q == StartByte) begin
            xor_d   = StartByte;
            cnt_d   = '0;
            phase_d = PH_FUNC_MSB;
          end
        end
        PH_FUNC_MSB: begin
          func_d  = {in_byte_q, ByteW'(0)};
          xor_d   = xor_q ^ in_byte_q;
          phase_d = PH_FUNC_LSB;
        end
        PH_FUNC_LSB: begin
          func_d  = {func_q[WordW-1:ByteW], in_byte_q};
          xor_d   = xor_q ^ in_byte_q;
          phase_d = PH_LEN_MSB;
        end
        PH_LEN_MSB: begin
          len_d   = {in_byte_q, ByteW'(0)};
          xor_d   = xor_q ^ in_byte_q;
          phase_d = PH_LEN_LSB;
        end
        PH_LEN_LSB: begin
          len_d   = {len_q[WordW-1:ByteW], in_byte_q};
          xor_d   = xor_q ^ in_byte_q;
          phase_d = (len_d == '0) ? PH_CHECKSUM : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          xor_d   = xor_q ^ in_byte_q;
          cnt_d   = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = PH_CHECKSUM;
          end
        end
        PH_CHECKSUM: begin
          phase_d = PH_WAIT;
        end
        default: begin
          phase_d = PH_WAIT;
        end
      endcase
    end
  end

  // result generation
  always_comb begin
    emit                 = 1'b0;
    res_d.result_kind    = KIND_PAYLOAD;
    res_d.function_code  = func_q;
    res_d.payload_length = len_q;
    res_d.byte_index     = cnt_q;
    res_d.byte_value     = in_byte_q;
    res_d.checksum_ok    = 1'b0;
    case (phase_q)
      PH_PAYLOAD: begin
        emit = 1'b1;
      end
      PH_CHECKSUM: begin
        emit              = 1'b1;
        res_d.result_kind = KIND_FRAME_END;
        res_d.checksum_ok = (in_byte_q == xor_q);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = in_vld_q && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      func_q    <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      xor_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      func_q    <= func_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      xor_q     <= xor_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q && emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.result_kind    = res_q.result_kind;
  assign res_o.function_code  = res_q.function_code;
  assign res_o.payload_length = res_q.payload_length;
  assign res_o.byte_index     = res_q.byte_index;
  assign res_o.byte_value     = res_q.byte_value;
  assign res_o.checksum_ok    = res_q.checksum_ok;

  // frame end always reports the full payload count
  a_end_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.result_kind == KIND_FRAME_END)
      |-> (res_q.byte_index == res_q.payload_length))
    else $error("frame end index differs from length");

  // payload results carry an in-range index and no checksum flag
  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.result_kind == KIND_PAYLOAD)
      |-> (!res_q.checksum_ok && res_q.byte_index < res_q.payload_length))
    else $error("bad payload result fields");

  // inside the payload the count stays below the declared length
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (cnt_q < len_q))
    else $error("payload count out of range");

  // input back-pressure only comes from a stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> (in_vld_q && out_vld_q && !res_o.ready))
    else $error("input stalled without cause");

  // a stalled input byte does not move the parser
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (phase_q == $past(phase_q) && xor_q == $past(xor_q)))
    else $error("parser moved while stalled");

endmodule
`default_nettype wire
